FILE: hdl/mup2x2_pkg.sv
// Shared types and constants for the 2x2 max-unpool scatter unit.
`timescale 1ns / 1ps

package mup2x2_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PLANE_WIDTH     = 2'd0;
  localparam logic [1:0] CFG_PLANE_HEIGHT    = 2'd1;
  localparam logic [1:0] CFG_MATCH_TOLERANCE = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DIM_W       = 11;
  localparam int ROW_W       = 10;

  localparam logic [DIM_W-1:0] MIN_DIM    = 11'd2;
  localparam logic [DIM_W-1:0] MAX_HEIGHT = 11'd1024;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef struct packed {
    logic signed [15:0] pixel_value;
    logic signed [15:0] window_max;
    logic signed [15:0] window_value;
  } pixel_in_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic               chosen;
    logic               last_of_plane;
  } pixel_out_t;

  // A classified pixel as handed from the front to the back.
  typedef struct packed {
    logic               clear;
    logic               match;
    logic signed [15:0] value;
    logic               last;
  } fe_item_t;

endpackage

FILE: hdl/max_unpool_2x2_scatter_unit.sv
// Top level of the streaming 2x2 max-unpool scatter unit.
`timescale 1ns / 1ps

// Pixels of each pre-pool plane enter in raster order with their window maximum
// and scatter value; each produces one result, the scatter value on the first
// pixel of its 2x2 window that matches the maximum within match_tolerance and
// zero elsewhere. The unit sustains one pixel per clock while pix_stall is low:
// the only loop is the read-modify-write of the per-window mark memory, which
// closes through a forwarding path. A pixel's result passes through the request
// queue, the mark read register and the result register. After reset the mark
// memory is cleared window by window, during which pix_stall stays high;
// configuration writes are taken at any time.
module max_unpool_2x2_scatter_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pix_valid,
  output logic                               pix_stall,
  input  mup2x2_pkg::pixel_in_t              pix_data,
  output logic                               res_valid,
  input  logic                               res_stall,
  output mup2x2_pkg::pixel_out_t             res_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mup2x2_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mup2x2_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW = $clog2((MAX_WIDTH + 1) / 2);

  logic                 busy;
  logic                 q_full;
  logic                 q_push;
  logic [IW-1:0]        push_idx;
  mup2x2_pkg::fe_item_t push_item;
  logic                 q_valid;
  logic                 q_pop;
  logic [IW-1:0]        pop_idx;
  mup2x2_pkg::fe_item_t pop_item;

  mup2x2_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_idx     (push_idx),
    .q_item    (push_item)
  );

  mup2x2_queue #(.IDX_W(IW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_idx  (push_idx),
    .push_item (push_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_idx   (pop_idx),
    .pop_item  (pop_item)
  );

  mup2x2_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_idx     (pop_idx),
    .q_item    (pop_item),
    .busy      (busy),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  // A request is never offered to a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("request pushed into a full queue");

  // No pixel is taken while the mark memory is being cleared.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(q_push || q_pop))
    else $error("request moved during the mark clearing pass");

  // A result that was not chosen carries zero.
  a_zero_unchosen: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.chosen) |-> (res_data.out_value == 16'sd0))
    else $error("unchosen result carries a nonzero value");

  // The clearing pass starts right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("mark clearing pass did not start after reset");

endmodule

FILE: hdl/mup2x2_front.sv
// Front end: configuration registers, raster counters and pixel classification.
`timescale 1ns / 1ps

module mup2x2_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pix_valid,
  output logic                                 pix_stall,
  input  mup2x2_pkg::pixel_in_t                pix_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mup2x2_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mup2x2_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                 busy,
  input  logic                                 q_full,
  output logic                                 q_push,
  output logic [$clog2((MAX_WIDTH + 1) / 2)-1:0] q_idx,
  output mup2x2_pkg::fe_item_t                 q_item
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int IW   = $clog2((MAX_WIDTH + 1) / 2);
  localparam int CMPW = ((CW > mup2x2_pkg::DIM_W) ? CW : mup2x2_pkg::DIM_W) + 1;

  logic [mup2x2_pkg::DIM_W-1:0] plane_width;
  logic [mup2x2_pkg::DIM_W-1:0] plane_height;
  logic [15:0]                  match_tolerance;
  logic [CW-1:0]                column_count;
  logic [mup2x2_pkg::ROW_W-1:0] row_count;

  logic [CMPW-1:0]              pw_ext;
  logic [CMPW-1:0]              w_eff;
  logic [CMPW-1:0]              w_last;
  logic [mup2x2_pkg::DIM_W-1:0] h_eff;
  logic [mup2x2_pkg::DIM_W-1:0] h_last;
  logic                         end_row;
  logic                         end_plane;
  logic signed [16:0]           diff;
  logic [16:0]                  abs_diff;
  logic                         accept;

  assign cfg_ready = 1'b1;
  assign pix_stall = busy || q_full;
  assign accept    = pix_valid && !pix_stall;

  always_comb begin
    pw_ext = CMPW'(plane_width);
    if (pw_ext < CMPW'(mup2x2_pkg::MIN_DIM)) begin
      w_eff = CMPW'(mup2x2_pkg::MIN_DIM);
    end else if (pw_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = pw_ext;
    end
    w_last = w_eff - CMPW'(1);

    if (plane_height < mup2x2_pkg::MIN_DIM) begin
      h_eff = mup2x2_pkg::MIN_DIM;
    end else if (plane_height > mup2x2_pkg::MAX_HEIGHT) begin
      h_eff = mup2x2_pkg::MAX_HEIGHT;
    end else begin
      h_eff = plane_height;
    end
    h_last = h_eff - mup2x2_pkg::DIM_W'(1);

    end_row   = CMPW'(column_count) >= w_last;
    end_plane = end_row && ({1'b0, row_count} >= h_last);

    diff     = 17'(pix_data.pixel_value) - 17'(pix_data.window_max);
    abs_diff = diff[16] ? $unsigned(-diff) : $unsigned(diff);
  end

  assign q_push       = accept;
  assign q_idx        = IW'(column_count >> 1);
  assign q_item.clear = !column_count[0] && !row_count[0];
  assign q_item.match = abs_diff <= {1'b0, match_tolerance};
  assign q_item.value = pix_data.window_value;
  assign q_item.last  = end_plane;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_width     <= mup2x2_pkg::MIN_DIM;
      plane_height    <= mup2x2_pkg::MIN_DIM;
      match_tolerance <= '0;
      column_count    <= '0;
      row_count       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mup2x2_pkg::CFG_PLANE_WIDTH:     plane_width     <= cfg_data[mup2x2_pkg::DIM_W-1:0];
          mup2x2_pkg::CFG_PLANE_HEIGHT:    plane_height    <= cfg_data[mup2x2_pkg::DIM_W-1:0];
          mup2x2_pkg::CFG_MATCH_TOLERANCE: match_tolerance <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (end_row) begin
          column_count <= '0;
          row_count    <= end_plane ? '0 : row_count + mup2x2_pkg::ROW_W'(1);
        end else begin
          column_count <= column_count + CW'(1);
        end
      end
    end
  end

endmodule

FILE: hdl/mup2x2_queue.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps

module mup2x2_queue #(
  parameter int IDX_W = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [IDX_W-1:0]     push_idx,
  input  mup2x2_pkg::fe_item_t push_item,
  output logic                 full,
  output logic                 pop_valid,
  input  logic                 pop,
  output logic [IDX_W-1:0]     pop_idx,
  output mup2x2_pkg::fe_item_t pop_item
);

  logic [IDX_W-1:0]                   idx_q  [mup2x2_pkg::QUEUE_DEPTH];
  mup2x2_pkg::fe_item_t               item_q [mup2x2_pkg::QUEUE_DEPTH];
  logic [mup2x2_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [mup2x2_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [mup2x2_pkg::QUEUE_PTR_W:0]   count;
  logic                               do_push;
  logic                               do_pop;

  assign full      = count == (mup2x2_pkg::QUEUE_PTR_W + 1)'(mup2x2_pkg::QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_idx   = idx_q[rd_ptr];
  assign pop_item  = item_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      idx_q[wr_ptr]  <= push_idx;
      item_q[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + mup2x2_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + mup2x2_pkg::QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (mup2x2_pkg::QUEUE_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (mup2x2_pkg::QUEUE_PTR_W + 1)'(1);
      end
    end
  end

endmodule

FILE: hdl/mup2x2_back.sv
// Back end: window mark memory read-modify-write and the result register.
`timescale 1ns / 1ps

module mup2x2_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  output logic                                   q_pop,
  input  logic [$clog2((MAX_WIDTH + 1) / 2)-1:0] q_idx,
  input  mup2x2_pkg::fe_item_t                   q_item,
  output logic                                   busy,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output mup2x2_pkg::pixel_out_t                 res_data
);

  localparam int NUM_WIN = (MAX_WIDTH + 1) / 2;
  localparam int IW      = $clog2(NUM_WIN);

  logic                 taken_mem [NUM_WIN];
  logic [IW-1:0]        clr_cnt;
  logic                 s1_valid;
  logic [IW-1:0]        s1_idx;
  mup2x2_pkg::fe_item_t s1_item;
  logic                 s1_rdata;
  logic                 s1_fwd;
  logic                 s1_fwd_bit;
  logic                 s1_adv;
  logic                 taken_eff;
  logic                 chosen;
  logic                 wr_bit;

  assign s1_adv = s1_valid && (!res_valid || !res_stall);
  assign q_pop  = q_valid && !busy && (!s1_valid || s1_adv);

  // The read for the next request is captured at the same edge as the write of
  // the request ahead of it, so a write to the same window is forwarded.
  assign taken_eff = s1_item.clear ? 1'b0 : (s1_fwd ? s1_fwd_bit : s1_rdata);
  assign chosen    = s1_item.match && !taken_eff;
  assign wr_bit    = taken_eff || chosen;

  always_ff @(posedge clk) begin
    if (busy) begin
      taken_mem[clr_cnt] <= 1'b0;
    end else if (s1_adv) begin
      taken_mem[s1_idx] <= wr_bit;
    end
    if (q_pop) begin
      s1_rdata   <= taken_mem[q_idx];
      s1_idx     <= q_idx;
      s1_item    <= q_item;
      s1_fwd     <= s1_adv && (s1_idx == q_idx);
      s1_fwd_bit <= wr_bit;
    end
    if (s1_adv) begin
      res_data.out_value     <= chosen ? s1_item.value : 16'sd0;
      res_data.chosen        <= chosen;
      res_data.last_of_plane <= s1_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      clr_cnt   <= '0;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (busy) begin
        clr_cnt <= clr_cnt + IW'(1);
        if (clr_cnt == IW'(NUM_WIN - 1)) begin
          busy <= 1'b0;
        end
      end
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: verif/mup2x2_checker.sv
// Result checker for the 2x2 max-unpool scatter unit: tracks requests and compares every result.
`timescale 1ns / 1ps

module mup2x2_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pix_valid,
  input  logic                               pix_stall,
  input  mup2x2_pkg::pixel_in_t              pix_data,
  input  logic                               res_valid,
  input  logic                               res_stall,
  input  mup2x2_pkg::pixel_out_t             res_data,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [mup2x2_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mup2x2_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                        error_count,
  output int unsigned                        pending,
  output int unsigned                        checked_count,
  output int unsigned                        chosen_count,
  output int unsigned                        plane_count
);

  localparam int unsigned NUM_WIN = (MAX_WIDTH + 1) / 2;

  logic [mup2x2_pkg::DIM_W-1:0] width_reg;
  logic [mup2x2_pkg::DIM_W-1:0] height_reg;
  logic [15:0]                  tolerance_reg;
  int unsigned                  col_pos;
  int unsigned                  row_pos;
  bit                           win_taken [NUM_WIN];
  mup2x2_pkg::pixel_out_t       unpooled_q [$];
  int unsigned                  errs = 0;
  int unsigned                  checked = 0;
  int unsigned                  picks = 0;
  int unsigned                  planes = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < mup2x2_pkg::MIN_DIM) return mup2x2_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the position counters and the window marks by one pixel.
  function automatic mup2x2_pkg::pixel_out_t unpool_pixel(mup2x2_pkg::pixel_in_t px);
    mup2x2_pkg::pixel_out_t r;
    int unsigned w;
    int unsigned h;
    int unsigned slot;
    int          diff;
    logic        pick;
    logic        end_row;
    logic        end_plane;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, mup2x2_pkg::MAX_HEIGHT);
    slot = col_pos >> 1;
    if (slot >= NUM_WIN) slot = NUM_WIN - 1;
    if (col_pos % 2 == 0 && row_pos % 2 == 0) win_taken[slot] = 1'b0;
    diff = int'($signed(px.pixel_value)) - int'($signed(px.window_max));
    if (diff < 0) diff = -diff;
    pick = (diff <= int'({16'd0, tolerance_reg})) && !win_taken[slot];
    if (pick) win_taken[slot] = 1'b1;
    end_row = col_pos >= w - 1;
    end_plane = end_row && row_pos >= h - 1;
    r.out_value = pick ? px.window_value : 16'sd0;
    r.chosen = pick;
    r.last_of_plane = end_plane;
    if (end_row) begin
      col_pos = 0;
      row_pos = end_plane ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    mup2x2_pkg::pixel_out_t want;
    mup2x2_pkg::pixel_out_t got;
    if (rst) begin
      width_reg = mup2x2_pkg::MIN_DIM;
      height_reg = mup2x2_pkg::MIN_DIM;
      tolerance_reg = '0;
      col_pos = 0;
      row_pos = 0;
      foreach (win_taken[i]) win_taken[i] = 1'b0;
      unpooled_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mup2x2_pkg::CFG_PLANE_WIDTH: width_reg = cfg_data[mup2x2_pkg::DIM_W-1:0];
          mup2x2_pkg::CFG_PLANE_HEIGHT: height_reg = cfg_data[mup2x2_pkg::DIM_W-1:0];
          mup2x2_pkg::CFG_MATCH_TOLERANCE: tolerance_reg = cfg_data;
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        got = res_data;
        if (unpooled_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%t: result with nothing outstanding: value %h chosen %b last %b",
                     $realtime, got.out_value, got.chosen, got.last_of_plane);
        end else begin
          want = unpooled_q.pop_front();
          checked++;
          if (want.chosen) picks++;
          if (want.last_of_plane) planes++;
          if (got.out_value !== want.out_value || got.chosen !== want.chosen ||
              got.last_of_plane !== want.last_of_plane) begin
            errs++;
            if (errs <= 10)
              $display("%t: result %0d: expected value %h chosen %b last %b, got %h %b %b",
                       $realtime, checked, want.out_value, want.chosen, want.last_of_plane,
                       got.out_value, got.chosen, got.last_of_plane);
          end
        end
      end
      if (pix_valid && !pix_stall) unpooled_q.push_back(unpool_pixel(pix_data));
    end
    error_count <= errs;
    pending <= unpooled_q.size();
    checked_count <= checked;
    chosen_count <= picks;
    plane_count <= planes;
  end

endmodule

FILE: verif/tb_max_unpool_2x2_scatter_unit.sv
// Testbench top for the 2x2 max-unpool scatter unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_max_unpool_2x2_scatter_unit;

  localparam int unsigned NUM_WIN_MAX = 0;
  localparam int unsigned MAX_W = 1024;
  localparam int unsigned NUM_WIN = (MAX_W + 1) / 2;
  localparam logic [mup2x2_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic signed [15:0] Q_MIN = 16'h8000;
  localparam logic signed [15:0] Q_MAX = 16'h7FFF;
  localparam int PHASES = 16;
  localparam int WIDE_PHASE = 10;
  localparam int PAUSE_PHASE = 6;

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               pix_valid = 1'b0;
  logic                               pix_stall;
  mup2x2_pkg::pixel_in_t              pix_data = '0;
  logic                               res_valid;
  logic                               res_stall = 1'b0;
  mup2x2_pkg::pixel_out_t             res_data;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [mup2x2_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mup2x2_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int unsigned error_count;
  int unsigned pending;
  int unsigned checked_count;
  int unsigned chosen_count;
  int unsigned plane_count;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Stimulus-side view of the raster position, used to keep windows consistent.
  logic [mup2x2_pkg::DIM_W-1:0] gen_width = mup2x2_pkg::MIN_DIM;
  logic [mup2x2_pkg::DIM_W-1:0] gen_height = mup2x2_pkg::MIN_DIM;
  int unsigned                  gen_tol = 0;
  int unsigned                  gen_col = 0;
  int unsigned                  gen_row = 0;
  logic signed [15:0]           plan_max [NUM_WIN];
  logic signed [15:0]           plan_val [NUM_WIN];

  max_unpool_2x2_scatter_unit #(
    .MAX_WIDTH(MAX_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix_data (pix_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  mup2x2_checker #(
    .MAX_WIDTH(MAX_W)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .pix_data     (pix_data),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res_data     (res_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .error_count  (error_count),
    .pending      (pending),
    .checked_count(checked_count),
    .chosen_count (chosen_count),
    .plane_count  (plane_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off so the unit backs up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      res_stall <= 1'b1;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < mup2x2_pkg::MIN_DIM) return mup2x2_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [15:0] pick_q88();
    case ($urandom_range(9))
      0: return Q_MIN;
      1: return Q_MAX;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed windows: one max and one scatter value per window, with
  // pixels that hit the max exactly or land near it; the rest is noise.
  function automatic mup2x2_pkg::pixel_in_t make_pixel();
    mup2x2_pkg::pixel_in_t px;
    int unsigned           slot;
    int unsigned           span;
    int                    near;
    int unsigned           roll;
    slot = gen_col / 2;
    if (slot >= NUM_WIN) slot = NUM_WIN - 1;
    if (gen_col % 2 == 0 && gen_row % 2 == 0) begin
      plan_max[slot] = pick_q88();
      plan_val[slot] = pick_q88();
    end
    px.window_max = plan_max[slot];
    px.window_value = plan_val[slot];
    roll = $urandom_range(99);
    if (roll < 12) begin
      px.pixel_value = 16'($urandom);
      px.window_max = 16'($urandom);
      px.window_value = 16'($urandom);
    end else if (roll < 45) begin
      px.pixel_value = plan_max[slot];
    end else if (roll < 70) begin
      span = (gen_tol > 300) ? 300 : gen_tol + 2;
      near = int'(plan_max[slot]) + int'($urandom_range(2 * span)) - int'(span);
      if (near > 32767) near = 32767;
      if (near < -32768) near = -32768;
      px.pixel_value = 16'(near);
    end else begin
      px.pixel_value = 16'($urandom);
    end
    return px;
  endfunction

  task automatic send_pixel(input mup2x2_pkg::pixel_in_t px);
    int unsigned w;
    int unsigned h;
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_data <= px;
    do @(posedge clk); while (pix_stall);
    w = clamp_dim(gen_width, MAX_W);
    h = clamp_dim(gen_height, mup2x2_pkg::MAX_HEIGHT);
    if (gen_col >= w - 1) begin
      gen_col = 0;
      gen_row = (gen_row >= h - 1) ? 0 : gen_row + 1;
    end else begin
      gen_col++;
    end
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [mup2x2_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mup2x2_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mup2x2_pkg::CFG_PLANE_WIDTH: gen_width = val[mup2x2_pkg::DIM_W-1:0];
      mup2x2_pkg::CFG_PLANE_HEIGHT: gen_height = val[mup2x2_pkg::DIM_W-1:0];
      mup2x2_pkg::CFG_MATCH_TOLERANCE: gen_tol = 32'(val);
      default: ;
    endcase
  endtask

  task automatic drain();
    pix_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int n_items;
    int unsigned roll;
    logic [mup2x2_pkg::CFG_DATA_W-1:0] val;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes and exact match: a pick, a repeat in a taken window, plane end.
    send_pixel('{16'sd100, 16'sd200, 16'sd5});
    send_pixel('{16'sd200, 16'sd200, Q_MIN});
    send_pixel('{16'sd200, 16'sd200, 16'sd7});
    send_pixel('{Q_MAX, Q_MAX, 16'sd1});
    send_pixel('{Q_MIN, Q_MAX, 16'sd9});
    drain();
    // Widest tolerance mid-plane, and a write to the unused index.
    write_reg(mup2x2_pkg::CFG_MATCH_TOLERANCE, 16'hFFFF);
    write_reg(CFG_UNUSED, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_pixel('{Q_MAX, Q_MIN, Q_MAX});
    send_pixel('{Q_MIN, Q_MAX, 16'sd3});
    send_pixel('{16'sd0, 16'sd0, Q_MIN});
    drain();
    // Sizes below and above range; tolerance edge of one LSB.
    write_reg(mup2x2_pkg::CFG_PLANE_WIDTH, 16'h0000);
    write_reg(mup2x2_pkg::CFG_PLANE_HEIGHT, 16'hFFFF);
    write_reg(mup2x2_pkg::CFG_MATCH_TOLERANCE, 16'h0001);
    cfg_valid <= 1'b0;
    send_pixel('{16'sd2, 16'sd0, 16'sd12});
    send_pixel('{-16'sd1, 16'sd0, 16'sd13});
    send_pixel('{16'sd0, 16'sd0, 16'sd14});
    send_pixel('{16'sd0, 16'sd0, 16'sd15});
    drain();
    // Odd width and height give one-column and one-row windows.
    write_reg(mup2x2_pkg::CFG_PLANE_WIDTH, 16'd5);
    write_reg(mup2x2_pkg::CFG_PLANE_HEIGHT, 16'd3);
    write_reg(mup2x2_pkg::CFG_MATCH_TOLERANCE, 16'h0000);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 10; i++) send_pixel('{16'sh0040, 16'sh0040, 16'(i + 1)});

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p < 5) begin
        send_idle_pct = 25;
        recv_idle_pct = 81;
      end else if (p < 10) begin
        send_idle_pct = 81;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == WIDE_PHASE) begin
        write_reg(mup2x2_pkg::CFG_PLANE_WIDTH, 16'd1024);
        write_reg(mup2x2_pkg::CFG_PLANE_HEIGHT, 16'd1024);
        write_reg(mup2x2_pkg::CFG_MATCH_TOLERANCE, 16'($urandom_range(64)));
      end else begin
        roll = $urandom_range(99);
        if (roll < 60) val = 16'($urandom_range(2, 9));
        else if (roll < 85) val = 16'($urandom_range(10, 40));
        else if (roll < 92) val = 16'($urandom_range(1));
        else val = 16'($urandom_range(1025, 2047));
        write_reg(mup2x2_pkg::CFG_PLANE_WIDTH,
                  {5'($urandom), val[mup2x2_pkg::DIM_W-1:0]});
        roll = $urandom_range(99);
        if (roll < 70) val = 16'($urandom_range(2, 6));
        else if (roll < 85) val = 16'($urandom_range(7, 20));
        else if (roll < 93) val = 16'($urandom_range(1));
        else val = 16'($urandom_range(1025, 2047));
        write_reg(mup2x2_pkg::CFG_PLANE_HEIGHT,
                  {5'($urandom), val[mup2x2_pkg::DIM_W-1:0]});
        roll = $urandom_range(99);
        if (roll < 30) val = 16'd0;
        else if (roll < 60) val = 16'($urandom_range(1, 64));
        else if (roll < 85) val = 16'($urandom);
        else val = 16'hFFFF;
        write_reg(mup2x2_pkg::CFG_MATCH_TOLERANCE, val);
      end
      cfg_valid <= 1'b0;
      if (p == WIDE_PHASE) hold_req <= 1'b1;
      n_items = (p == WIDE_PHASE) ? 1026 : $urandom_range(6, 18);
      for (int i = 0; i < n_items; i++) begin
        // Once, the sender waits mid-stream until every result is back.
        if (p == PAUSE_PHASE && i == n_items / 2) drain();
        send_pixel(make_pixel());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d pixel results: %0d scatter picks, %0d plane ends, %0d settings.",
             checked_count, chosen_count, plane_count, PHASES + 4);
    $display("Stimulus covered clamped and odd sizes, a full 1024-pixel row and long stalls.");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
